### hdl/kmh_pkg.sv
package kmh_pkg;

    // default sizes
    localparam int HEAP_DEPTH_DEF = 64;
    localparam int ID_WIDTH_DEF   = 16;

    // fixed field widths
    localparam int DIST_W     = 32;
    localparam int PID_W      = 16;
    localparam int CNT_W      = 7;
    localparam int SLOT_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'd1;

    // reset values of the configuration registers
    localparam logic [CNT_W-1:0]  WANTED_RST = 7'd1;
    localparam logic [DIST_W-1:0] RADIUS_RST = 32'hFFFF_FFFF;

    // candidate beat
    typedef struct packed {
        logic [PID_W-1:0]  point_id;
        logic [DIST_W-1:0] sq_distance;
        logic              last_candidate;
    } cand_t;

    // result beat
    typedef struct packed {
        logic [PID_W-1:0]  out_point_id;
        logic [DIST_W-1:0] out_distance;
        logic [SLOT_W-1:0] slot_index;
        logic [CNT_W-1:0]  found_total;
        logic              entry_valid;
        logic              last_result;
    } res_t;

endpackage

### hdl/kmh_ram.sv
module kmh_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/k_nearest_max_heap_top.sv
// k-nearest selection over a bounded max-heap keyed by squared distance.
// cand channel (valid/ready): one beat per candidate of a query; the beat
//   with last_candidate set closes the query.
// res channel (valid/ready): on a closing beat the heap slots are sent in
//   array order, one beat each, or one empty marker when nothing was kept.
// cfg port: plain write, index 0 wanted_count, index 1 radius_limit; write
//   only while the block is idle.
// Flow: a candidate is taken only in the idle state; a rejected one is
//   not written to the heap. An insertion climbs from the free slot toward
//   the root; a replacement of the top sinks from the root toward a leaf.
//   The heap sits in one RAM with registered read, so each level costs one
//   or two read turns and a compare/write turn.
// Readout: each result beat takes a RAM read, then a load of the output
//   register; the next slot is read only once the result register is free.
// Reset: no entries, wanted_count 1, radius all ones; the RAM is not
//   cleared, only slots below the fill count are ever read.
// Stalls: the result register holds its beat until taken; readout waits on
//   it, and candidates of the next query are taken while the last beat of
//   the previous readout still waits.
module k_nearest_max_heap_top #(
    parameter int HEAP_DEPTH = kmh_pkg::HEAP_DEPTH_DEF,
    parameter int ID_WIDTH   = kmh_pkg::ID_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cand_valid,
    output logic                             cand_ready,
    input  kmh_pkg::cand_t                   cand,
    output logic                             res_valid,
    input  logic                             res_ready,
    output kmh_pkg::res_t                    res,
    input  logic                             cfg_we,
    input  logic [kmh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kmh_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import kmh_pkg::*;

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int LW = AW + 2;
    localparam int MW = DIST_W + ID_WIDTH;

    // sequencer codes
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_UP_RD    = 4'd1;
    localparam logic [3:0] S_UP_CMP   = 4'd2;
    localparam logic [3:0] S_DN_RDL   = 4'd3;
    localparam logic [3:0] S_DN_RDR   = 4'd4;
    localparam logic [3:0] S_DN_CMP   = 4'd5;
    localparam logic [3:0] S_FIN      = 4'd6;
    localparam logic [3:0] S_RO_ISSUE = 4'd7;
    localparam logic [3:0] S_RO_LOAD  = 4'd8;

    logic [3:0]          state_reg,   state_next;
    logic [DIST_W-1:0]   v_dist_reg,  v_dist_next;
    logic [ID_WIDTH-1:0] v_id_reg,    v_id_next;
    logic                last_reg,    last_next;
    logic [AW-1:0]       pos_reg,     pos_next;
    logic [DIST_W-1:0]   cl_dist_reg, cl_dist_next;
    logic [ID_WIDTH-1:0] cl_id_reg,   cl_id_next;
    logic                r_ok_reg,    r_ok_next;
    logic [CW-1:0]       found_reg,   found_next;
    logic                full_reg,    full_next;
    logic [DIST_W-1:0]   limit_reg,   limit_next;
    logic [DIST_W-1:0]   top_reg,     top_next;
    logic [CNT_W-1:0]    wanted_reg,  wanted_next;
    logic [DIST_W-1:0]   radius_reg,  radius_next;
    logic [CW-1:0]       ridx_reg,    ridx_next;
    logic                res_valid_reg, res_valid_next;
    res_t                res_reg,     res_next;

    // heap RAM ports
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [MW-1:0]       ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [MW-1:0]       ram_rdata;
    logic [DIST_W-1:0]   rd_dist;
    logic [ID_WIDTH-1:0] rd_id;

    // helpers
    logic                cand_acc;
    logic                out_free;
    logic [CNT_W-1:0]    wanted_eff;
    logic [CNT_W-1:0]    found_ext;
    logic [LW-1:0]       l_ext;
    logic [LW-1:0]       r_ext;
    logic [LW-1:0]       size_ext;
    logic [AW-1:0]       parent;
    logic                take_r;
    logic                take_l;

    kmh_ram #(
        .WIDTH (MW),
        .DEPTH (HEAP_DEPTH)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_dist = ram_rdata[MW-1:ID_WIDTH];
    assign rd_id   = ram_rdata[ID_WIDTH-1:0];

    assign cand_ready = (state_reg == S_IDLE);
    assign cand_acc   = cand_valid && cand_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;
    assign out_free   = !res_valid_reg || res_ready;

    // effective wanted count, clamped to 1..depth
    always_comb
    begin
        if (wanted_reg == '0)
        begin
            wanted_eff = CNT_W'(1);
        end
        else if (wanted_reg > CNT_W'(HEAP_DEPTH))
        begin
            wanted_eff = CNT_W'(HEAP_DEPTH);
        end
        else
        begin
            wanted_eff = wanted_reg;
        end
    end

    // heap index arithmetic
    assign found_ext = CNT_W'(found_reg);
    assign l_ext     = LW'({pos_reg, 1'b1});
    assign r_ext     = l_ext + LW'(1);
    assign size_ext  = LW'(found_reg);
    assign parent    = AW'((pos_reg - AW'(1)) >> 1);

    // sift-down child choice, left wins ties
    assign take_r = r_ok_reg && (rd_dist > v_dist_reg) && (rd_dist > cl_dist_reg);
    assign take_l = !take_r && (cl_dist_reg > v_dist_reg);

    // sequencer and datapath
    always_comb
    begin
        state_next     = state_reg;
        v_dist_next    = v_dist_reg;
        v_id_next      = v_id_reg;
        last_next      = last_reg;
        pos_next       = pos_reg;
        cl_dist_next   = cl_dist_reg;
        cl_id_next     = cl_id_reg;
        r_ok_next      = r_ok_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        limit_next     = limit_reg;
        wanted_next    = wanted_reg;
        radius_next    = radius_reg;
        ridx_next      = ridx_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = {v_dist_reg, v_id_reg};
        ram_re         = 1'b0;
        ram_raddr      = pos_reg;

        // configuration writes, to be made only while idle; the block does not enforce this
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WANTED:
                begin
                    wanted_next = CNT_W'(cfg_data);
                end
                CFG_RADIUS:
                begin
                    radius_next = cfg_data;
                    if (!full_reg)
                    begin
                        limit_next = cfg_data;
                    end
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cand_acc)
                begin
                    v_dist_next = cand.sq_distance;
                    v_id_next   = ID_WIDTH'(cand.point_id);
                    last_next   = cand.last_candidate;
                    ridx_next   = '0;
                    if (cand.sq_distance < limit_reg)
                    begin
                        if (full_reg)
                        begin
                            pos_next   = '0;
                            state_next = S_DN_RDL;
                        end
                        else if (found_ext < CNT_W'(HEAP_DEPTH))
                        begin
                            pos_next   = AW'(found_reg);
                            found_next = found_reg + CW'(1);
                            state_next = S_UP_RD;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    else if (cand.last_candidate)
                    begin
                        state_next = S_RO_ISSUE;
                    end
                end
            end

            // sift-up: fetch the parent, or settle at the root
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = parent;
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (rd_dist < v_dist_reg)
                begin
                    // parent moves down into the hole
                    ram_wdata  = ram_rdata;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            // sift-down: fetch the left child, or settle at a leaf
            S_DN_RDL:
            begin
                if (l_ext < size_ext)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(l_ext);
                    state_next = S_DN_RDR;
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = S_FIN;
                end
            end

            S_DN_RDR:
            begin
                cl_dist_next = rd_dist;
                cl_id_next   = rd_id;
                r_ok_next    = (r_ext < size_ext);
                if (r_ext < size_ext)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_ext);
                end
                state_next = S_DN_CMP;
            end

            S_DN_CMP:
            begin
                ram_we = 1'b1;
                if (take_r)
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = AW'(r_ext);
                    state_next = S_DN_RDL;
                end
                else if (take_l)
                begin
                    ram_wdata  = {cl_dist_reg, cl_id_reg};
                    pos_next   = AW'(l_ext);
                    state_next = S_DN_RDL;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            // limit follows the top once full
            S_FIN:
            begin
                if (full_reg || found_ext >= wanted_eff || found_ext >= CNT_W'(HEAP_DEPTH))
                begin
                    full_next  = 1'b1;
                    limit_next = top_reg;
                end
                state_next = last_reg ? S_RO_ISSUE : S_IDLE;
            end

            // readout: once the result register is free, read a slot or send the empty marker
            S_RO_ISSUE:
            begin
                if (out_free)
                begin
                    if (found_reg == '0)
                    begin
                        res_next.out_point_id = '0;
                        res_next.out_distance = '0;
                        res_next.slot_index   = '0;
                        res_next.found_total  = '0;
                        res_next.entry_valid  = 1'b0;
                        res_next.last_result  = 1'b1;
                        res_valid_next        = 1'b1;
                        full_next             = 1'b0;
                        limit_next            = radius_reg;
                        state_next            = S_IDLE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = ridx_reg[AW-1:0];
                        state_next = S_RO_LOAD;
                    end
                end
            end

            S_RO_LOAD:
            begin
                res_next.out_point_id = PID_W'(rd_id);
                res_next.out_distance = rd_dist;
                res_next.slot_index   = SLOT_W'(ridx_reg);
                res_next.found_total  = found_ext;
                res_next.entry_valid  = 1'b1;
                res_next.last_result  = (ridx_reg + CW'(1) == found_reg);
                res_valid_next        = 1'b1;
                ridx_next             = ridx_reg + CW'(1);
                if (ridx_reg + CW'(1) == found_reg)
                begin
                    // clear for the next query
                    found_next = '0;
                    full_next  = 1'b0;
                    limit_next = radius_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RO_ISSUE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // heap top tracks writes to the root slot
    always_comb
    begin
        top_next = top_reg;
        if (ram_we && ram_waddr == '0)
        begin
            top_next = ram_wdata[MW-1:ID_WIDTH];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            found_reg     <= '0;
            full_reg      <= 1'b0;
            limit_reg     <= RADIUS_RST;
            wanted_reg    <= WANTED_RST;
            radius_reg    <= RADIUS_RST;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            found_reg     <= found_next;
            full_reg      <= full_next;
            limit_reg     <= limit_next;
            wanted_reg    <= wanted_next;
            radius_reg    <= radius_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        v_dist_reg  <= v_dist_next;
        v_id_reg    <= v_id_next;
        last_reg    <= last_next;
        pos_reg     <= pos_next;
        cl_dist_reg <= cl_dist_next;
        cl_id_reg   <= cl_id_next;
        r_ok_reg    <= r_ok_next;
        top_reg     <= top_next;
        ridx_reg    <= ridx_next;
        res_reg     <= res_next;
    end

endmodule

### dv/kmh_checker.sv
`timescale 1ns / 100ps

module kmh_checker #(
    parameter int HEAP_DEPTH = kmh_pkg::HEAP_DEPTH_DEF,
    parameter int ID_WIDTH   = kmh_pkg::ID_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cand_valid,
    input  logic                            cand_ready,
    input  kmh_pkg::cand_t                  cand,
    input  logic                            res_valid,
    input  logic                            res_ready,
    input  kmh_pkg::res_t                   res,
    input  logic                            cfg_we,
    input  logic [kmh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kmh_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              fail_count,
    output int                              outstanding,
    output int                              beats_seen,
    output int                              queries_seen
);

    import kmh_pkg::*;

    localparam logic [31:0] ID_MASK = (ID_WIDTH >= 32) ? 32'hFFFF_FFFF
                                      : 32'((64'd1 << ID_WIDTH) - 64'd1);
    localparam int MAX_SHOWN = 40;

    // own copy of the heap and its bookkeeping
    logic [DIST_W-1:0] heap_dist [HEAP_DEPTH];
    logic [31:0]       heap_pid  [HEAP_DEPTH];
    int                fill;
    bit                full;
    logic [DIST_W-1:0] limit_q;
    logic [CNT_W-1:0]  wanted_reg;
    logic [DIST_W-1:0] radius_reg;
    res_t              slot_q [$];
    int                shown;

    // effective kept count: zero acts as one, saturates at depth
    function automatic int keep_count();
        int w;
        w = int'(wanted_reg);
        if (w == 0)
        begin
            w = 1;
        end
        if (w > HEAP_DEPTH)
        begin
            w = HEAP_DEPTH;
        end
        return w;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [DIST_W-1:0] d;
        logic [31:0]       p;
        d = heap_dist[a];
        p = heap_pid[a];
        heap_dist[a] = heap_dist[b];
        heap_pid[a]  = heap_pid[b];
        heap_dist[b] = d;
        heap_pid[b]  = p;
    endfunction

    // move a new entry toward the root while its parent is strictly smaller
    function automatic void climb(int pos);
        int up;
        while (pos > 0 && pos < HEAP_DEPTH)
        begin
            up = (pos - 1) >> 1;
            if (!(heap_dist[up] < heap_dist[pos]))
            begin
                break;
            end
            swap_slots(up, pos);
            pos = up;
        end
    endfunction

    // push the root down; left child wins on equal children
    function automatic void sink(int size);
        int pos, l, r, big;
        pos = 0;
        if (size > HEAP_DEPTH)
        begin
            size = HEAP_DEPTH;
        end
        while (1)
        begin
            l   = 2 * pos + 1;
            r   = l + 1;
            big = pos;
            if (l < size && heap_dist[l] > heap_dist[big])
            begin
                big = l;
            end
            if (r < size && heap_dist[r] > heap_dist[big] && heap_dist[r] > heap_dist[l])
            begin
                big = r;
            end
            if (big == pos)
            begin
                break;
            end
            swap_slots(pos, big);
            pos = big;
        end
    endfunction

    // update the heap with one candidate, queue readout beats on a closing one
    function automatic void take_candidate(cand_t c);
        logic [31:0] pid;
        res_t        r;
        int          i;
        pid = 32'(c.point_id) & ID_MASK;
        if (c.sq_distance < limit_q)
        begin
            if (!full)
            begin
                if (fill < HEAP_DEPTH)
                begin
                    heap_dist[fill] = c.sq_distance;
                    heap_pid[fill]  = pid;
                    climb(fill);
                    fill++;
                end
                if (fill >= keep_count() || fill >= HEAP_DEPTH)
                begin
                    full    = 1'b1;
                    limit_q = heap_dist[0];
                end
            end
            else
            begin
                heap_dist[0] = c.sq_distance;
                heap_pid[0]  = pid;
                sink(fill);
                limit_q = heap_dist[0];
            end
        end
        if (c.last_candidate)
        begin
            if (fill == 0)
            begin
                r = '0;
                r.last_result = 1'b1;
                slot_q.push_back(r);
            end
            else
            begin
                for (i = 0; i < fill && i < HEAP_DEPTH; i++)
                begin
                    r.out_point_id = heap_pid[i][PID_W-1:0];
                    r.out_distance = heap_dist[i];
                    r.slot_index   = SLOT_W'(i);
                    r.found_total  = CNT_W'(fill);
                    r.entry_valid  = 1'b1;
                    r.last_result  = (i + 1 == fill);
                    slot_q.push_back(r);
                end
            end
            fill    = 0;
            full    = 1'b0;
            limit_q = radius_reg;
        end
    endfunction

    function automatic void note_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got && shown < MAX_SHOWN)
        begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // watch the three ports at each edge
    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        bit   bad;
        if (!rst_n)
        begin
            fill       = 0;
            full       = 1'b0;
            wanted_reg = WANTED_RST;
            radius_reg = RADIUS_RST;
            limit_q    = RADIUS_RST;
            shown      = 0;
            slot_q.delete();
            fail_count   <= 0;
            outstanding  <= 0;
            beats_seen   <= 0;
            queries_seen <= 0;
        end
        else
        begin
            bad = 1'b0;
            // result beats first, so a fresh candidate never covers a stray beat
            if (res_valid && res_ready)
            begin
                beats_seen <= beats_seen + 1;
                if (res.last_result)
                begin
                    queries_seen <= queries_seen + 1;
                end
                if (slot_q.size() == 0)
                begin
                    bad = 1'b1;
                    if (shown < MAX_SHOWN)
                    begin
                        $display("%0t unexpected result beat: expected none actual %h",
                                 $time, res);
                    end
                end
                else
                begin
                    want = slot_q.pop_front();
                    if (res !== want)
                    begin
                        bad = 1'b1;
                        note_field("out_point_id", 64'(want.out_point_id), 64'(res.out_point_id));
                        note_field("out_distance", 64'(want.out_distance), 64'(res.out_distance));
                        note_field("slot_index", 64'(want.slot_index), 64'(res.slot_index));
                        note_field("found_total", 64'(want.found_total), 64'(res.found_total));
                        note_field("entry_valid", 64'(want.entry_valid), 64'(res.entry_valid));
                        note_field("last_result", 64'(want.last_result), 64'(res.last_result));
                    end
                end
            end
            // register writes
            if (cfg_we)
            begin
                if (cfg_index == CFG_WANTED)
                begin
                    wanted_reg = cfg_data[CNT_W-1:0];
                end
                else if (cfg_index == CFG_RADIUS)
                begin
                    radius_reg = cfg_data;
                    if (!full)
                    begin
                        limit_q = radius_reg;
                    end
                end
            end
            // candidate beats
            if (cand_valid && cand_ready)
            begin
                take_candidate(cand);
            end
            if (bad)
            begin
                shown++;
                fail_count <= fail_count + 1;
            end
            outstanding <= slot_q.size();
        end
    end

endmodule

### dv/tb_k_nearest_max_heap_top.sv
`timescale 1ns / 100ps

module tb_k_nearest_max_heap_top;
    import kmh_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int TOTAL_ITEMS   = 350;
    localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  cand_valid;
    logic                  cand_ready;
    cand_t                 cand;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    res_t                  res;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int outstanding;
    int beats_seen;
    int queries_seen;
    int snd_idle_pct = 7;
    int rcv_idle_pct = 75;
    int items_sent   = 0;
    int quiet_cycles = 0;

    k_nearest_max_heap_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand_valid),
        .cand_ready (cand_ready),
        .cand       (cand),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    kmh_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cand_valid   (cand_valid),
        .cand_ready   (cand_ready),
        .cand         (cand),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .beats_seen   (beats_seen),
        .queries_seen (queries_seen)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (cand_valid && cand_ready) || (res_valid && res_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one candidate beat, with random gaps ahead of it
    task automatic send(input logic [PID_W-1:0] pid, input logic [DIST_W-1:0] sq_dist,
                        input logic last);
        if (items_sent >= 2 * TOTAL_ITEMS / 3)
        begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
        else if (items_sent >= TOTAL_ITEMS / 3)
        begin
            snd_idle_pct = 75;
            rcv_idle_pct = 7;
        end
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            cand_valid <= 1'b0;
            @(posedge clk);
        end
        cand_valid <= 1'b1;
        cand       <= '{point_id: pid, sq_distance: sq_dist, last_candidate: last};
        do
        begin
            @(posedge clk);
        end
        while (!cand_ready);
        items_sent++;
    endtask

    // stop sending, let every readout beat come back, then let the block go idle
    task automatic settle();
        cand_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mix of full range, small values with many ties, and values near both ends
    function automatic logic [DIST_W-1:0] pick_distance();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return $urandom_range(0, 63);
            2:       return DIST_MAX - $urandom_range(0, 3);
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    initial
    begin
        int          qlen;
        int          k;
        int          wanted;
        logic [31:0] radius;
        bit          deep_done;

        rst_n      = 1'b0;
        cand_valid <= 1'b0;
        cand       <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= CFG_WANTED;
        cfg_data   <= '0;
        deep_done  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: keep one, open radius; extreme ids and distances
        send(16'hFFFF, DIST_MAX - 32'd1, 1'b0);
        send(16'h0000, 32'd0, 1'b1);
        send(16'h1234, DIST_MAX, 1'b1);

        // keep four: ties, a reject at the radius, then replacements of the top
        settle();
        set_reg(CFG_WANTED, 32'd4);
        set_reg(CFG_RADIUS, 32'd1000);
        send(16'd1, 32'd500, 1'b0);
        send(16'd2, 32'd500, 1'b0);
        send(16'd3, 32'd999, 1'b0);
        send(16'd4, 32'd1000, 1'b0);
        send(16'd5, 32'd10, 1'b0);
        send(16'd6, 32'd700, 1'b0);
        send(16'd7, 32'd500, 1'b0);
        send(16'd8, 32'd0, 1'b1);

        // wanted count of zero behaves as one
        settle();
        set_reg(CFG_WANTED, 32'd0);
        set_reg(CFG_RADIUS, 32'd100);
        send(16'd9, 32'd50, 1'b0);
        send(16'd10, 32'd40, 1'b1);

        // zero radius rejects everything: empty marker
        settle();
        set_reg(CFG_RADIUS, 32'd0);
        send(16'd11, 32'd0, 1'b1);

        // oversized wanted count, then lowered in the middle of a query
        settle();
        set_reg(CFG_WANTED, 32'd127);
        set_reg(CFG_RADIUS, DIST_MAX);
        send(16'd12, 32'd50, 1'b0);
        send(16'd13, 32'd60, 1'b0);
        settle();
        set_reg(CFG_WANTED, 32'd2);
        send(16'd14, 32'd40, 1'b0);
        // radius written while full only applies after the clear
        settle();
        set_reg(CFG_RADIUS, 32'd20);
        send(16'd15, 32'd30, 1'b1);
        send(16'd16, 32'd25, 1'b1);

        // radius written while not full reloads the limit at once
        settle();
        set_reg(CFG_WANTED, 32'd5);
        set_reg(CFG_RADIUS, 32'd100);
        send(16'd17, 32'd80, 1'b0);
        settle();
        set_reg(CFG_RADIUS, 32'd70);
        send(16'd18, 32'd75, 1'b0);
        send(16'd19, 32'd65, 1'b1);

        // random queries, reconfigured now and then while idle
        k = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            if (!deep_done && items_sent > TOTAL_ITEMS / 2)
            begin
                // one deep query that fills all slots and keeps replacing the top
                settle();
                set_reg(CFG_WANTED, {$urandom_range(0, 1) ? 32'd127 : 32'd64});
                set_reg(CFG_RADIUS, DIST_MAX);
                qlen      = 75;
                deep_done = 1'b1;
            end
            else
            begin
                if (k == 0 || $urandom_range(0, 1))
                begin
                    case ($urandom_range(0, 9))
                        0:       wanted = 0;
                        1:       wanted = 127;
                        2:       wanted = 64;
                        default: wanted = $urandom_range(1, 8);
                    endcase
                    case ($urandom_range(0, 3))
                        0:       radius = $urandom;
                        1:       radius = $urandom_range(0, 80);
                        default: radius = DIST_MAX;
                    endcase
                    settle();
                    set_reg(CFG_WANTED, ($urandom & ~32'h7F) | 32'(wanted));
                    set_reg(CFG_RADIUS, radius);
                end
                qlen = $urandom_range(1, 12);
            end
            for (k = 0; k < qlen; k++)
            begin
                send(16'($urandom_range(0, 65535)), pick_distance(), k == qlen - 1);
            end
        end

        settle();
        $display("covered %0d candidates over %0d queries, %0d result beats checked",
                 items_sent, queries_seen, beats_seen);
        $display("with gaps on both sides in turn, register extremes and mid-query writes");
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
